// ===== sv/ths_pkg.sv =====
// ----------------------------------------------------------------------------
// ths_pkg
// Types and codes shared by the timer heap / ready scheduler.
// ----------------------------------------------------------------------------
package ths_pkg;

  localparam int unsigned MAX_RESULTS  = 16;
  localparam int unsigned HANDLE_WIDTH = 16;
  localparam int unsigned TIME_WIDTH   = 32;

  typedef enum logic [1:0] {
    OP_POST     = 2'd0,
    OP_SCHEDULE = 2'd1,
    OP_RUN      = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_RESUME   = 2'd2,
    ST_IDLE     = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]              operation;
    logic [HANDLE_WIDTH-1:0] task_handle;
    logic [TIME_WIDTH-1:0]   deadline;
    logic [TIME_WIDTH-1:0]   now_time;
  } in_item_t;

  typedef struct packed {
    logic [HANDLE_WIDTH-1:0] out_handle;
    logic [1:0]              status;
    logic                    last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_RUN_CHK,
    S_POP_LAST,
    S_SIFT_RD,
    S_SIFT_CMP,
    S_EMIT_RD,
    S_EMIT,
    S_RESP
  } state_t;

endpackage

// ===== sv/timer_heap_ready_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// timer_heap_ready_scheduler_top
// Timer min-heap and ready FIFO scheduler, both held in block memories.
// ----------------------------------------------------------------------------
// Usage:
//   in_* channel takes one item: post (append handle to ready FIFO), schedule
//   (insert timer into the heap) or run (move expired timers to the FIFO,
//   then emit the ready handles). out_* channel returns result items; the
//   final result of each input item carries last. Operation code 3 is
//   dropped without a result.
//   Post answers straight from idle. Schedule compares up to log2
//   TIMER_DEPTH parents, a read and a compare step each. Run pops each
//   expired timer and sifts the moved element down level by level, then
//   emits the ready handles one by one.
//   The heap is one memory with one read port; each compare/swap needs a
//   read step and a compare step, which sets the rate.
//   One item is worked at a time; in_stall is high while busy.
//   Results leave through one output register; a stalled receiver simply
//   holds the sequencer until the result is taken.
//   Reset clears the counts and sequence; memory contents stay undefined
//   and are never read before written.
// ----------------------------------------------------------------------------
module timer_heap_ready_scheduler_top #(
  parameter int unsigned TIMER_DEPTH  = 16,
  parameter int unsigned READY_DEPTH  = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ths_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output ths_pkg::out_item_t out_item
);

  localparam int unsigned HANDLE_WIDTH = ths_pkg::HANDLE_WIDTH;
  localparam int unsigned TIME_WIDTH   = ths_pkg::TIME_WIDTH;
  localparam int unsigned TA = (TIMER_DEPTH > 1) ? $clog2(TIMER_DEPTH) : 1;
  localparam int unsigned RA = (READY_DEPTH > 1) ? $clog2(READY_DEPTH) : 1;
  localparam int unsigned TC = $clog2(TIMER_DEPTH + 1);
  localparam int unsigned RC = $clog2(READY_DEPTH + 1);

  typedef struct packed {
    logic [TIME_WIDTH-1:0]   dl;
    logic [HANDLE_WIDTH-1:0] hd;
    logic [31:0]             sq;
  } ent_t;

  // Heap memory: one write, one read port, registered read.
  // A read of the entry written in the same cycle returns the new data.
  ent_t                  heap_mem [TIMER_DEPTH];
  logic                  hw_en;
  logic [TA-1:0]         hw_addr;
  ent_t                  hw_data;
  logic [TA-1:0]         hr_addr;
  ent_t                  hr_data_r;

  always_ff @(posedge clk) begin
    if (hw_en) begin
      heap_mem[hw_addr] <= hw_data;
    end
    if (hw_en && hw_addr == hr_addr) begin
      hr_data_r <= hw_data;
    end else begin
      hr_data_r <= heap_mem[hr_addr];
    end
  end

  // Ready FIFO memory.
  logic [HANDLE_WIDTH-1:0] rdy_mem [READY_DEPTH];
  logic                    rw_en;
  logic [RA-1:0]           rw_addr;
  logic [HANDLE_WIDTH-1:0] rw_data;
  logic [RA-1:0]           rr_addr;
  logic [HANDLE_WIDTH-1:0] rr_data_r;

  always_ff @(posedge clk) begin
    if (rw_en) begin
      rdy_mem[rw_addr] <= rw_data;
    end
    rr_data_r <= rdy_mem[rr_addr];
  end

  ths_pkg::state_t state_r, state_nxt;
  logic [TC-1:0]   hcnt_r, hcnt_nxt;
  logic [31:0]     seq_r, seq_nxt;
  logic [RA-1:0]   rhead_r, rhead_nxt;
  logic [RC-1:0]   rcnt_r, rcnt_nxt;
  ths_pkg::in_item_t req_r, req_nxt;
  ent_t            cur_r, cur_nxt;     // element being sifted
  ent_t            top_r, top_nxt;     // left child (sift-down)
  logic [TA-1:0]   pos_r, pos_nxt;
  logic            lsel_r, lsel_nxt;   // sift-down: left child read pending
  logic [4:0]      nemit_r, nemit_nxt; // handles left to emit
  logic            ov_r, ov_nxt;
  ths_pkg::out_item_t oi_r, oi_nxt;

  // Ordering: deadline, then serial-number sequence.
  function automatic logic ent_before(ent_t a, ent_t b);
    logic [31:0] d;
    d = a.sq - b.sq;
    if (a.dl != b.dl) return a.dl < b.dl;
    return d[31];
  endfunction

  logic [TA:0] lchild, rchild;
  logic [TA-1:0] parent;
  logic [RA:0] tail_sum;
  logic [RA-1:0] rtail;
  logic [RC-1:0] rc_ext;
  assign lchild = {pos_r, 1'b1};
  assign rchild = {pos_r, 1'b1} + (TA+1)'(1);
  assign parent = TA'((pos_r - TA'(1)) >> 1);
  // Tail wraps by one compare and subtract.
  assign tail_sum = {1'b0, rhead_r} + (RA+1)'(rcnt_r);
  assign rtail  = (tail_sum >= (RA+1)'(READY_DEPTH)) ?
                  RA'(tail_sum - (RA+1)'(READY_DEPTH)) : RA'(tail_sum);
  assign rc_ext = rcnt_r;

  always_comb begin
    state_nxt = state_r;
    hcnt_nxt  = hcnt_r;
    seq_nxt   = seq_r;
    rhead_nxt = rhead_r;
    rcnt_nxt  = rcnt_r;
    req_nxt   = req_r;
    cur_nxt   = cur_r;
    top_nxt   = top_r;
    pos_nxt   = pos_r;
    lsel_nxt  = lsel_r;
    nemit_nxt = nemit_r;
    ov_nxt    = ov_r;
    oi_nxt    = oi_r;
    hw_en = 1'b0; hw_addr = pos_r; hw_data = cur_r;
    hr_addr = parent;
    rw_en = 1'b0; rw_addr = rtail; rw_data = req_r.task_handle[HANDLE_WIDTH-1:0];
    rr_addr = rhead_r;
    in_stall = 1'b1;

    if (ov_r && !out_stall) ov_nxt = 1'b0;

    unique case (state_r)
      ths_pkg::S_IDLE: begin
        in_stall = ov_r;
        if (in_valid && !ov_r) begin
          req_nxt = in_item;
          unique case (in_item.operation)
            ths_pkg::OP_POST: begin
              if (rcnt_r >= RC'(READY_DEPTH)) begin
                oi_nxt = '{16'd0, ths_pkg::ST_FULL, 1'b1};
              end else begin
                rw_en = 1'b1;
                rw_data = in_item.task_handle[HANDLE_WIDTH-1:0];
                rcnt_nxt = rcnt_r + RC'(1);
                oi_nxt = '{16'd0, ths_pkg::ST_ACCEPTED, 1'b1};
              end
              state_nxt = ths_pkg::S_RESP;
            end
            ths_pkg::OP_SCHEDULE: begin
              if (hcnt_r >= TC'(TIMER_DEPTH)) begin
                oi_nxt = '{16'd0, ths_pkg::ST_FULL, 1'b1};
                state_nxt = ths_pkg::S_RESP;
              end else begin
                cur_nxt = '{in_item.deadline[TIME_WIDTH-1:0],
                            in_item.task_handle[HANDLE_WIDTH-1:0], seq_r};
                seq_nxt = seq_r + 32'd1;
                pos_nxt = TA'(hcnt_r);
                hcnt_nxt = hcnt_r + TC'(1);
                oi_nxt = '{16'd0, ths_pkg::ST_ACCEPTED, 1'b1};
                state_nxt = ths_pkg::S_INS_RD;
              end
            end
            ths_pkg::OP_RUN: begin
              hr_addr = '0;
              state_nxt = ths_pkg::S_RUN_CHK;
            end
            default: ;
          endcase
        end
      end
      ths_pkg::S_INS_RD: begin
        if (pos_r == '0) begin
          hw_en = 1'b1;
          state_nxt = ths_pkg::S_RESP;
        end else begin
          hr_addr = parent;
          state_nxt = ths_pkg::S_INS_CMP;
        end
      end
      ths_pkg::S_INS_CMP: begin
        if (ent_before(cur_r, hr_data_r)) begin
          hw_en = 1'b1; hw_data = hr_data_r;
          pos_nxt = parent;
          state_nxt = ths_pkg::S_INS_RD;
        end else begin
          hw_en = 1'b1;
          state_nxt = ths_pkg::S_RESP;
        end
      end
      ths_pkg::S_RUN_CHK: begin
        // hr_data_r holds root
        if (hcnt_r != '0 && hr_data_r.dl <= req_r.now_time[TIME_WIDTH-1:0]
            && rcnt_r < RC'(READY_DEPTH)) begin
          rw_en = 1'b1; rw_data = hr_data_r.hd;
          rcnt_nxt = rcnt_r + RC'(1);
          hcnt_nxt = hcnt_r - TC'(1);
          hr_addr = TA'(hcnt_r - TC'(1));
          state_nxt = ths_pkg::S_POP_LAST;
        end else begin
          nemit_nxt = (rc_ext > RC'(ths_pkg::MAX_RESULTS)) ?
                      5'(ths_pkg::MAX_RESULTS) : 5'(rc_ext);
          if (rcnt_r == '0) begin
            oi_nxt = '{16'd0, ths_pkg::ST_IDLE, 1'b1};
            state_nxt = ths_pkg::S_RESP;
          end else begin
            state_nxt = ths_pkg::S_EMIT_RD;
          end
        end
      end
      ths_pkg::S_POP_LAST: begin
        // hr_data_r = last element, becomes sifted element at root
        cur_nxt = hr_data_r;
        pos_nxt = '0;
        if (hcnt_r == '0) begin
          hr_addr = '0;
          state_nxt = ths_pkg::S_RUN_CHK;
        end else begin
          hr_addr = TA'(1);
          lsel_nxt = 1'b0;
          state_nxt = ths_pkg::S_SIFT_RD;
        end
      end
      ths_pkg::S_SIFT_RD: begin
        // issue read of left child (right child is read from S_SIFT_CMP)
        if ((TC+1)'(lchild) >= (TC+1)'(hcnt_r)) begin
          hw_en = 1'b1;
          hr_addr = '0;
          state_nxt = ths_pkg::S_RUN_CHK;
        end else if (!lsel_r) begin
          hr_addr = TA'(lchild);
          lsel_nxt = 1'b1;
          state_nxt = ths_pkg::S_SIFT_CMP;
        end
      end
      ths_pkg::S_SIFT_CMP: begin
        if (lsel_r) begin
          // left child arrived
          top_nxt = hr_data_r;
          lsel_nxt = 1'b0;
          if ((TC+1)'(rchild) < (TC+1)'(hcnt_r)) begin
            hr_addr = TA'(rchild);
            // stay in this state until the right child arrives
          end else begin
            if (ent_before(hr_data_r, cur_r)) begin
              hw_en = 1'b1; hw_data = hr_data_r;
              pos_nxt = TA'(lchild);
              state_nxt = ths_pkg::S_SIFT_RD;
            end else begin
              hw_en = 1'b1;
              hr_addr = '0;
              state_nxt = ths_pkg::S_RUN_CHK;
            end
          end
        end else begin
          // right child in hr_data_r, left in top_r; right is checked
          // against the smaller of left and the sifted element
          if (ent_before(top_r, cur_r) ? ent_before(hr_data_r, top_r)
                                       : ent_before(hr_data_r, cur_r)) begin
            hw_en = 1'b1; hw_data = hr_data_r;
            pos_nxt = TA'(rchild);
            state_nxt = ths_pkg::S_SIFT_RD;
          end else if (ent_before(top_r, cur_r)) begin
            hw_en = 1'b1; hw_data = top_r;
            pos_nxt = TA'(lchild);
            state_nxt = ths_pkg::S_SIFT_RD;
          end else begin
            hw_en = 1'b1;
            hr_addr = '0;
            state_nxt = ths_pkg::S_RUN_CHK;
          end
        end
      end
      ths_pkg::S_EMIT_RD: begin
        rr_addr = rhead_r;
        if (!ov_r || !out_stall) state_nxt = ths_pkg::S_EMIT;
      end
      ths_pkg::S_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          oi_nxt.out_handle = 16'(rr_data_r);
          oi_nxt.status = ths_pkg::ST_RESUME;
          oi_nxt.last = (nemit_r == 5'd1);
          rhead_nxt = (rhead_r == RA'(READY_DEPTH - 1)) ? '0 : rhead_r + RA'(1);
          rcnt_nxt = rcnt_r - RC'(1);
          nemit_nxt = nemit_r - 5'd1;
          rr_addr = rhead_nxt;
          state_nxt = (nemit_r == 5'd1) ? ths_pkg::S_IDLE : ths_pkg::S_EMIT_RD;
        end
      end
      ths_pkg::S_RESP: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          state_nxt = ths_pkg::S_IDLE;
        end
      end
      default: state_nxt = ths_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ths_pkg::S_IDLE;
      hcnt_r  <= '0;
      seq_r   <= '0;
      rhead_r <= '0;
      rcnt_r  <= '0;
      ov_r    <= 1'b0;
      lsel_r  <= 1'b0;
      nemit_r <= '0;
    end else begin
      state_r <= state_nxt;
      hcnt_r  <= hcnt_nxt;
      seq_r   <= seq_nxt;
      rhead_r <= rhead_nxt;
      rcnt_r  <= rcnt_nxt;
      ov_r    <= ov_nxt;
      lsel_r  <= lsel_nxt;
      nemit_r <= nemit_nxt;
    end
    req_r <= req_nxt;
    cur_r <= cur_nxt;
    top_r <= top_nxt;
    pos_r <= pos_nxt;
    oi_r  <= oi_nxt;
  end

  assign out_valid = ov_r;
  assign out_item  = oi_r;

`ifndef SYNTHESIS
  a_hcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hcnt_r <= TC'(TIMER_DEPTH)) else $error("heap count overflow");
  a_rcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= RC'(READY_DEPTH)) else $error("ready count overflow");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ths_pkg::S_IDLE |-> in_stall) else $error("accepted while busy");
`endif

endmodule

// ===== sim/tb_timer_heap_ready_scheduler_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timer_heap_ready_scheduler_top
// Self-checking bench for the timer heap / ready FIFO scheduler. A local
// model of the heap and FIFO predicts every result item; results are checked
// in order, field by field, under random sender and receiver idling.
// ----------------------------------------------------------------------------
module tb_timer_heap_ready_scheduler_top;

  localparam int unsigned TDEPTH = 16;
  localparam int unsigned RDEPTH = 16;
  localparam int unsigned RES_SLOTS = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  ths_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall = 1'b0;
  ths_pkg::out_item_t out_item;

  timer_heap_ready_scheduler_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Idle rates in percent for each side.
  int unsigned send_gap_pct;
  int unsigned recv_stall_pct;
  int unsigned failures = 0;
  int unsigned cycle_count = 0;

  // Predicted results, oldest first (ring, written by sender, read by receiver).
  ths_pkg::out_item_t res_buf[RES_SLOTS];
  int unsigned res_wr = 0;
  int unsigned res_rd = 0;

  // Scheduler state as predicted.
  logic [31:0] t_deadline[TDEPTH];
  logic [15:0] t_handle[TDEPTH];
  logic [31:0] t_seq[TDEPTH];
  int unsigned timer_count;
  logic [31:0] seq_next;
  logic [15:0] rq_store[RDEPTH];
  int unsigned rq_head;
  int unsigned rq_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[timer_heap_ready_scheduler_top] ERROR");
      $finish;
    end
  end

  // Timer a is due before timer b: deadline, then serial-number sequence.
  function automatic bit timer_earlier(int unsigned a, int unsigned b);
    logic [31:0] diff;
    if (t_deadline[a] != t_deadline[b]) return t_deadline[a] < t_deadline[b];
    diff = t_seq[a] - t_seq[b];
    return diff[31];
  endfunction

  function automatic void timer_exchange(int unsigned a, int unsigned b);
    logic [31:0] d;
    logic [15:0] h;
    logic [31:0] s;
    d = t_deadline[a]; h = t_handle[a]; s = t_seq[a];
    t_deadline[a] = t_deadline[b]; t_handle[a] = t_handle[b]; t_seq[a] = t_seq[b];
    t_deadline[b] = d; t_handle[b] = h; t_seq[b] = s;
  endfunction

  function automatic void push_result(logic [15:0] h, ths_pkg::status_t st, logic lst);
    ths_pkg::out_item_t r;
    r.out_handle = h;
    r.status     = st;
    r.last       = lst;
    res_buf[res_wr % RES_SLOTS] = r;
    res_wr++;
  endfunction

  function automatic void rq_append(logic [15:0] h);
    rq_store[(rq_head + rq_count) % RDEPTH] = h;
    rq_count++;
  endfunction

  function automatic logic [15:0] rq_take();
    logic [15:0] h;
    h = rq_store[rq_head];
    rq_head = (rq_head + 1) % RDEPTH;
    rq_count--;
    return h;
  endfunction

  // Predicts the results of one accepted item and updates the state.
  function automatic void predict_schedule(ths_pkg::in_item_t it);
    int unsigned i, p, l, r, m, n;
    case (ths_pkg::op_t'(it.operation))
      ths_pkg::OP_POST: begin
        if (rq_count >= RDEPTH) push_result('0, ths_pkg::ST_FULL, 1'b1);
        else begin
          rq_append(it.task_handle);
          push_result('0, ths_pkg::ST_ACCEPTED, 1'b1);
        end
      end
      ths_pkg::OP_SCHEDULE: begin
        if (timer_count >= TDEPTH) push_result('0, ths_pkg::ST_FULL, 1'b1);
        else begin
          i = timer_count;
          t_deadline[i] = it.deadline;
          t_handle[i]   = it.task_handle;
          t_seq[i]      = seq_next;
          seq_next++;
          timer_count++;
          while (i > 0) begin
            p = (i - 1) / 2;
            if (!timer_earlier(i, p)) break;
            timer_exchange(i, p);
            i = p;
          end
          push_result('0, ths_pkg::ST_ACCEPTED, 1'b1);
        end
      end
      ths_pkg::OP_RUN: begin
        while (timer_count > 0 && t_deadline[0] <= it.now_time &&
               rq_count < RDEPTH) begin
          rq_append(t_handle[0]);
          timer_count--;
          if (timer_count > 0) begin
            timer_exchange(0, timer_count);
            i = 0;
            forever begin
              l = 2 * i + 1;
              r = l + 1;
              m = i;
              if (l < timer_count && timer_earlier(l, m)) m = l;
              if (r < timer_count && timer_earlier(r, m)) m = r;
              if (m == i) break;
              timer_exchange(i, m);
              i = m;
            end
          end
        end
        n = rq_count;
        if (n > ths_pkg::MAX_RESULTS) n = ths_pkg::MAX_RESULTS;
        if (n == 0) push_result('0, ths_pkg::ST_IDLE, 1'b1);
        for (int unsigned k = 0; k < n; k++)
          push_result(rq_take(), ths_pkg::ST_RESUME, k + 1 == n);
      end
      default: ;
    endcase
  endfunction

  // Receiver: random stall, compares each taken result with the oldest one.
  always @(posedge clk) begin
    ths_pkg::out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (res_wr == res_rd) begin
          $error("unexpected result item: handle %0h status %0d last %0b",
                 out_item.out_handle, out_item.status, out_item.last);
          failures++;
        end else begin
          want = res_buf[res_rd % RES_SLOTS];
          res_rd++;
          if (out_item.out_handle !== want.out_handle) begin
            $error("out_handle: expected %0h, got %0h", want.out_handle, out_item.out_handle);
            failures++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            failures++;
          end
          if (out_item.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_item.last);
            failures++;
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Sends one item, with a random idle gap first; predicts on acceptance.
  task automatic send_item(ths_pkg::op_t op, logic [15:0] h, logic [31:0] dl,
                           logic [31:0] now);
    ths_pkg::in_item_t it;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    it.operation   = op;
    it.task_handle = h;
    it.deadline    = dl;
    it.now_time    = now;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    predict_schedule(it);
  endtask

  function automatic logic [31:0] rand_word();
    return $urandom();
  endfunction

  // Waits until every predicted result has been taken, then some slack.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (res_wr != res_rd) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Extremes of each field, both full cases, idle run and code 3.
  task automatic test_directed();
    send_item(ths_pkg::OP_RUN, 16'h0000, 32'h0, 32'hFFFF_FFFF);          // nothing ready
    send_item(ths_pkg::OP_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // ignored
    send_item(ths_pkg::OP_POST, 16'hFFFF, 32'h0, 32'h0);
    send_item(ths_pkg::OP_POST, 16'h0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(ths_pkg::OP_SCHEDULE, 16'hA5A5, 32'hFFFF_FFFF, 32'h0);
    send_item(ths_pkg::OP_SCHEDULE, 16'h5A5A, 32'h0, 32'h0);
    send_item(ths_pkg::OP_SCHEDULE, 16'h1234, 32'h0, 32'h0);             // tie, later sequence
    send_item(ths_pkg::OP_RUN, 16'h0, 32'h0, 32'h0);
    send_item(ths_pkg::OP_RUN, 16'h0, 32'h0, 32'hFFFF_FFFF);
    // Fill heap past depth: overflow drops.
    for (int i = 0; i < 18; i++) send_item(ths_pkg::OP_SCHEDULE, 16'(i), 32'd5, 32'h0);
    send_item(ths_pkg::OP_RUN, 16'h0, 32'h0, 32'd100);                   // all timers move, FIFO fills
    drain_results();
  endtask

  // Post overflow: FIFO full then a run emitting the maximum.
  task automatic test_ready_full();
    for (int i = 0; i < 17; i++)
      send_item(ths_pkg::OP_POST, 16'($urandom()), rand_word(), rand_word());
    send_item(ths_pkg::OP_RUN, 16'h0, 32'h0, 32'h0);
    send_item(ths_pkg::OP_RUN, 16'h0, 32'h0, 32'hFFFF_FFFF);
    send_item(ths_pkg::OP_RUN, 16'h0, 32'h0, 32'hFFFF_FFFF);
    drain_results();
  endtask

  // Random mix: mostly schedules and posts between runs at rising times.
  task automatic test_random(int unsigned count);
    logic [31:0] clock_now;
    int unsigned sel;
    clock_now = $urandom_range(1000);
    for (int unsigned i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 30)
        send_item(ths_pkg::OP_POST, 16'($urandom()), rand_word(), rand_word());
      else if (sel < 65)
        send_item(ths_pkg::OP_SCHEDULE, 16'($urandom()),
                  ($urandom_range(9) == 0) ? rand_word() : clock_now + $urandom_range(200),
                  rand_word());
      else if (sel < 97) begin
        clock_now = clock_now + $urandom_range(120);
        send_item(ths_pkg::OP_RUN, 16'($urandom()), rand_word(),
                  ($urandom_range(19) == 0) ? rand_word() : clock_now);
      end else send_item(ths_pkg::OP_NONE, 16'($urandom()), rand_word(), rand_word());
    end
    send_item(ths_pkg::OP_RUN, 16'h0, 32'h0, 32'hFFFF_FFFF);
    drain_results();
  endtask

  initial begin
    timer_count  = 0;
    seq_next     = '0;
    rq_head      = 0;
    rq_count     = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_item      = '0;
    send_gap_pct   = 25;
    recv_stall_pct = 85;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_ready_full();
    test_random(90);
    send_gap_pct   = 85;
    recv_stall_pct = 25;
    test_random(90);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    test_random(100);

    if (failures == 0) $display("[timer_heap_ready_scheduler_top] OK");
    else $display("[timer_heap_ready_scheduler_top] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
sv/ths_pkg.sv
sv/timer_heap_ready_scheduler_top.sv
sim/tb_timer_heap_ready_scheduler_top.sv
